// File: design/ppb_pkg.sv
package ppb_pkg;

    localparam int S_TDATA_W = 224;
    localparam int M_TDATA_W = 160;
    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;
    localparam int QDEPTH    = 4;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_ACCEL_X,
        REG_ACCEL_Y,
        REG_STEP_X,
        REG_STEP_Y,
        REG_ROT_T,
        REG_ROT_S
    } reg_idx_t;

    typedef struct packed {
        logic               mag;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic [59:0]        rot_t;
        logic [59:0]        rot_s;
    } cfg_t;

    // One classified item. For a load, ni/nj is the node; for a push, the
    // lower-left node of the cell and the weights already ordered by bank.
    typedef struct packed {
        logic               is_push;
        logic [6:0]         ni;
        logic [6:0]         nj;
        logic [3:0][16:0]   wt;
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic [21:0]        px;
        logic [21:0]        py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } q_entry_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return 32'(v);
        end
    endfunction

    // Drop 16 fraction bits, rounding half up.
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
        return (p + 64'sd32768) >>> 16;
    endfunction

endpackage

// File: design/ppb_front.sv
module ppb_front #(
    parameter int CELLS_X = 64,
    parameter int CELLS_Y = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ppb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    output logic                          q_valid,
    input  logic                          q_ready,
    output ppb_pkg::q_entry_t             q_data
);
    import ppb_pkg::*;

    logic                 f_valid_reg;
    logic                 f_user_reg;
    logic [S_TDATA_W-1:0] f_data_reg;

    logic [6:0]  nx, ny;
    logic [21:0] px, py;
    logic        is_push, load_ok, f_free;
    logic [5:0]  ix, iy;
    logic [16:0] fx, fy;
    logic [33:0] prod;
    logic [16:0] w1, w2, w3, w4;
    logic [3:0][16:0] wt;

    assign nx      = f_data_reg[6:0];
    assign ny      = f_data_reg[13:7];
    assign px      = f_data_reg[99:78];
    assign py      = f_data_reg[121:100];
    assign is_push = f_user_reg;
    assign load_ok = (int'(nx) <= CELLS_X) && (int'(ny) <= CELLS_Y);

    always_comb begin
        ix = px[21:16];
        iy = py[21:16];
        fx = {1'b0, px[15:0]};
        fy = {1'b0, py[15:0]};
        // Beyond the last cell the gather sits on the far edge nodes.
        if (int'(ix) >= CELLS_X) begin
            ix = 6'(CELLS_X - 1);
            fx = 17'h10000;
        end
        if (int'(iy) >= CELLS_Y) begin
            iy = 6'(CELLS_Y - 1);
            fy = 17'h10000;
        end
    end

    // All four weights come from the one product fx*fy.
    assign prod = fx * fy;
    assign w4 = 17'((35'(prod) + 35'd32768) >> 16);
    assign w2 = 17'((35'({fx, 16'h0}) - 35'(prod) + 35'd32768) >> 16);
    assign w3 = 17'((35'({fy, 16'h0}) - 35'(prod) + 35'd32768) >> 16);
    assign w1 = 17'((35'h1_0000_0000 - 35'({fx, 16'h0}) - 35'({fy, 16'h0})
                     + 35'(prod) + 35'd32768) >> 16);

    // Bank {p,q} holds the node whose column parity is p and row parity q.
    always_comb begin
        logic di, dj;
        for (int b = 0; b < 4; b++) begin
            di = 1'(b >> 1) ^ ix[0];
            dj = 1'(b) ^ iy[0];
            case ({di, dj})
                2'b00:   wt[b] = w1;
                2'b10:   wt[b] = w2;
                2'b01:   wt[b] = w3;
                default: wt[b] = w4;
            endcase
        end
    end

    always_comb begin
        q_data         = '0;
        q_data.is_push = is_push;
        q_data.ni      = is_push ? {1'b0, ix} : nx;
        q_data.nj      = is_push ? {1'b0, iy} : ny;
        q_data.wt      = wt;
        q_data.field_x = f_data_reg[45:14];
        q_data.field_y = f_data_reg[77:46];
        q_data.px      = px;
        q_data.py      = py;
        q_data.vx      = f_data_reg[153:122];
        q_data.vy      = f_data_reg[185:154];
        q_data.vz      = f_data_reg[217:186];
    end

    // Loads aimed outside the grid are dropped here.
    assign q_valid  = f_valid_reg && (is_push || load_ok);
    assign f_free   = !q_valid || q_ready;
    assign s_tready = !f_valid_reg || f_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_tready) begin
            f_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            f_user_reg <= s_tuser[0];
            f_data_reg <= s_tdata;
        end
    end

endmodule

// File: design/ppb_queue.sv
module ppb_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ppb_pkg::q_entry_t in_data,
    output logic              out_valid,
    input  logic              out_pop,
    output ppb_pkg::q_entry_t out_data
);
    import ppb_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    q_entry_t      slot_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = cnt_reg != (PW + 1)'(QDEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: design/ppb_back.sv
module ppb_back #(
    parameter int CELLS_X = 64,
    parameter int CELLS_Y = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ppb_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  ppb_pkg::q_entry_t             q_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ppb_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [0:0]                    m_tuser
);
    import ppb_pkg::*;

    localparam int BS         = CELLS_Y / 2 + 1;
    localparam int BANK_DEPTH = (CELLS_X / 2 + 1) * BS;
    localparam int BAW        = $clog2(BANK_DEPTH);
    localparam int NST        = 10;
    localparam logic signed [31:0] LIM_X = 32'(CELLS_X * 65536);
    localparam logic signed [31:0] LIM_Y = 32'(CELLS_Y * 65536);

    typedef struct packed {
        logic [21:0]        px;
        logic [21:0]        py;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
    } push_t;

    logic adv;

    logic     b0_valid_reg, b1_valid_reg;
    q_entry_t b0_reg, b1_reg;
    logic [BAW-1:0]     addr_next [4];
    logic [BAW-1:0]     addr_reg  [4];
    logic signed [63:0] lpx_reg, lpy_reg;
    logic [63:0]        wdata;
    logic [1:0]         wbank;
    logic               wr_en;
    logic [63:0]        rd_reg [4];

    logic [3:0][16:0]   wt_reg;
    logic signed [49:0] gx_reg [4];
    logic signed [49:0] gy_reg [4];
    logic signed [51:0] tp_reg [6];
    logic signed [51:0] sp_reg [6];
    logic signed [63:0] mp_reg [2];

    logic  pv_reg [NST];
    push_t st_reg [NST];
    push_t st_next [NST];

    logic signed [19:0] tx, ty, tz, sx, sy, sz;
    logic signed [63:0] dx, dy;
    logic signed [31:0] nxo, nyo;
    logic               off;

    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    // The whole back end moves as one; it holds only while a result waits.
    assign adv   = !m_tvalid_reg || m_tready;
    assign q_pop = adv && q_valid;

    assign tx = cfg.rot_t[19:0];
    assign ty = cfg.rot_t[39:20];
    assign tz = cfg.rot_t[59:40];
    assign sx = cfg.rot_s[19:0];
    assign sy = cfg.rot_s[39:20];
    assign sz = cfg.rot_s[59:40];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg <= 1'b0;
            b1_valid_reg <= 1'b0;
            for (int k = 0; k < NST; k++) begin
                pv_reg[k] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            b0_valid_reg <= q_valid;
            b1_valid_reg <= b0_valid_reg;
            pv_reg[0]    <= b1_valid_reg && b1_reg.is_push;
            for (int k = 1; k < NST; k++) begin
                pv_reg[k] <= pv_reg[k-1];
            end
            m_tvalid_reg <= pv_reg[NST-1];
        end
    end

    // Bank addresses: each bank takes the node of the cell with its parity.
    for (genvar g = 0; g < 4; g++) begin : g_addr
        localparam logic P = 1'(g >> 1);
        localparam logic Q = 1'(g);
        logic [6:0] isel, jsel;
        assign isel = (b0_reg.ni[0] == P) ? b0_reg.ni : 7'(b0_reg.ni + 7'd1);
        assign jsel = (b0_reg.nj[0] == Q) ? b0_reg.nj : 7'(b0_reg.nj + 7'd1);
        assign addr_next[g] = BAW'(int'(isel >> 1) * BS + int'(jsel >> 1));
    end

    assign wbank = {b1_reg.ni[0], b1_reg.nj[0]};
    assign wr_en = adv && b1_valid_reg && !b1_reg.is_push;
    assign wdata = {sat32(rnd16(lpy_reg)), sat32(rnd16(lpx_reg))};

    // Loads write and pushes read at the same stage, so order is kept.
    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [63:0] mem [BANK_DEPTH];
        always_ff @(posedge aclk) begin
            if (wr_en && wbank == 2'(g)) begin
                mem[addr_reg[g]] <= wdata;
            end
            if (adv) begin
                rd_reg[g] <= mem[addr_reg[g]];
            end
        end
    end

    always_comb begin
        st_next[0]    = '0;
        st_next[0].px = b1_reg.px;
        st_next[0].py = b1_reg.py;
        st_next[0].vx = b1_reg.vx;
        st_next[0].vy = b1_reg.vy;
        st_next[0].vz = b1_reg.vz;

        st_next[1] = st_reg[0];

        st_next[2]    = st_reg[1];
        st_next[2].ax = sat32(rnd16(64'(gx_reg[0]) + 64'(gx_reg[1])
                                    + 64'(gx_reg[2]) + 64'(gx_reg[3])));
        st_next[2].ay = sat32(rnd16(64'(gy_reg[0]) + 64'(gy_reg[1])
                                    + 64'(gy_reg[2]) + 64'(gy_reg[3])));

        st_next[3]    = st_reg[2];
        st_next[3].vx = sat32(64'(st_reg[2].vx) + 64'(st_reg[2].ax));
        st_next[3].vy = sat32(64'(st_reg[2].vy) + 64'(st_reg[2].ay));

        st_next[4] = st_reg[3];

        st_next[5]    = st_reg[4];
        st_next[5].rx = sat32(64'(st_reg[4].vx) + rnd16(64'(tp_reg[0]))
                              - rnd16(64'(tp_reg[1])));
        st_next[5].ry = sat32(64'(st_reg[4].vy) + rnd16(64'(tp_reg[2]))
                              - rnd16(64'(tp_reg[3])));
        st_next[5].rz = sat32(64'(st_reg[4].vz) + rnd16(64'(tp_reg[4]))
                              - rnd16(64'(tp_reg[5])));

        st_next[6] = st_reg[5];

        // Plain mode keeps the once-accelerated velocity from here on.
        st_next[7] = st_reg[6];
        if (cfg.mag) begin
            st_next[7].vx = sat32(64'(st_reg[6].vx) + rnd16(64'(sp_reg[0]))
                                  - rnd16(64'(sp_reg[1])));
            st_next[7].vy = sat32(64'(st_reg[6].vy) + rnd16(64'(sp_reg[2]))
                                  - rnd16(64'(sp_reg[3])));
            st_next[7].vz = sat32(64'(st_reg[6].vz) + rnd16(64'(sp_reg[4]))
                                  - rnd16(64'(sp_reg[5])));
        end

        st_next[8] = st_reg[7];
        if (cfg.mag) begin
            st_next[8].vx = sat32(64'(st_reg[7].vx) + 64'(st_reg[7].ax));
            st_next[8].vy = sat32(64'(st_reg[7].vy) + 64'(st_reg[7].ay));
        end

        st_next[9] = st_reg[8];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b0_reg  <= q_data;
            b1_reg  <= b0_reg;
            addr_reg <= addr_next;
            lpx_reg <= b0_reg.field_x * cfg.accel_x;
            lpy_reg <= b0_reg.field_y * cfg.accel_y;
            wt_reg  <= b1_reg.wt;
            for (int g = 0; g < 4; g++) begin
                gx_reg[g] <= $signed(rd_reg[g][31:0]) * $signed({1'b0, wt_reg[g]});
                gy_reg[g] <= $signed(rd_reg[g][63:32]) * $signed({1'b0, wt_reg[g]});
            end
            tp_reg[0] <= st_reg[3].vy * tz;
            tp_reg[1] <= st_reg[3].vz * ty;
            tp_reg[2] <= st_reg[3].vz * tx;
            tp_reg[3] <= st_reg[3].vx * tz;
            tp_reg[4] <= st_reg[3].vx * ty;
            tp_reg[5] <= st_reg[3].vy * tx;
            sp_reg[0] <= st_reg[5].ry * sz;
            sp_reg[1] <= st_reg[5].rz * sy;
            sp_reg[2] <= st_reg[5].rz * sx;
            sp_reg[3] <= st_reg[5].rx * sz;
            sp_reg[4] <= st_reg[5].rx * sy;
            sp_reg[5] <= st_reg[5].ry * sx;
            mp_reg[0] <= cfg.step_x * st_reg[8].vx;
            mp_reg[1] <= cfg.step_y * st_reg[8].vy;
            for (int k = 0; k < NST; k++) begin
                st_reg[k] <= st_next[k];
            end
            m_tdata_reg <= {st_reg[NST-1].vz, st_reg[NST-1].vy, st_reg[NST-1].vx,
                            nyo, nxo};
            m_tuser_reg <= off;
        end
    end

    assign dx  = cfg.mag ? rnd16(mp_reg[0]) : 64'(st_reg[NST-1].vx);
    assign dy  = cfg.mag ? rnd16(mp_reg[1]) : 64'(st_reg[NST-1].vy);
    assign nxo = sat32(64'($signed({1'b0, st_reg[NST-1].px})) + dx);
    assign nyo = sat32(64'($signed({1'b0, st_reg[NST-1].py})) + dy);
    assign off = (nxo < 0) || (nyo < 0) || (nxo >= LIM_X) || (nyo >= LIM_Y);

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// File: design/pic_particle_push_bilinear_top.sv
// Particle push for a 2D particle-in-cell grid with bilinear field gather.
// Input stream (s_*): s_tuser[0] = 0 is a load beat that stores one node's
// field, scaled into acceleration; s_tuser[0] = 1 is a push beat carrying
// one particle. Loads give no output beat; each push gives exactly one
// m_* beat with the new position, new velocity and an out-of-grid flag.
// Settings (mode, scales, Boris t and s vectors) sit on the APB port at
// byte address 8*i and may only be written while no push is in flight.
// Throughput is one beat per cycle on both sides, loads and pushes mixed, while m_tready stays high.
// A push passes from its input beat to its output beat through one front
// register, one queue slot, twelve back stages led by the banked node memory
// read and two Boris multiplier rounds, and the output register.
// The node grid is split into four parity banks so all four corner nodes of
// a cell are read in the same cycle.
// While a result waits with m_tready low the back end holds; the queue
// keeps taking beats until it fills, then s_tready drops. Reset empties
// every stage and restores the register defaults; node memory is not
// cleared, and a node must be loaded before any particle gathers from it.
module pic_particle_push_bilinear_top #(
    parameter int CELLS_X = 64,
    parameter int CELLS_Y = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // node_x, node_y, field_x, field_y, pos_x, pos_y, vel_x, vel_y, vel_z
    input  logic [ppb_pkg::S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_vel_z
    output logic [ppb_pkg::M_TDATA_W-1:0] m_tdata,
    // out_of_grid
    output logic [0:0]                    m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppb_pkg::APB_AW-1:0]    paddr,
    input  logic [ppb_pkg::APB_DW-1:0]    pwdata,
    output logic [ppb_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import ppb_pkg::*;

    logic               mode_reg;
    logic signed [31:0] accel_x_reg, accel_y_reg, step_x_reg, step_y_reg;
    logic [59:0]        rot_t_reg, rot_s_reg;
    reg_idx_t           idx;
    logic               cfg_wr;
    cfg_t               cfg;

    logic     q_in_valid, q_in_ready, q_out_valid, q_pop;
    q_entry_t q_in_data, q_out_data;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[5:3]);
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= 1'b0;
            accel_x_reg <= 32'sd65536;
            accel_y_reg <= 32'sd65536;
            step_x_reg  <= 32'sd65536;
            step_y_reg  <= 32'sd65536;
            rot_t_reg   <= '0;
            rot_s_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (idx)
                REG_MODE:    mode_reg    <= pwdata[0];
                REG_ACCEL_X: accel_x_reg <= pwdata[31:0];
                REG_ACCEL_Y: accel_y_reg <= pwdata[31:0];
                REG_STEP_X:  step_x_reg  <= pwdata[31:0];
                REG_STEP_Y:  step_y_reg  <= pwdata[31:0];
                REG_ROT_T:   rot_t_reg   <= pwdata[59:0];
                REG_ROT_S:   rot_s_reg   <= pwdata[59:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE:    prdata = {63'b0, mode_reg};
            REG_ACCEL_X: prdata = {32'b0, accel_x_reg};
            REG_ACCEL_Y: prdata = {32'b0, accel_y_reg};
            REG_STEP_X:  prdata = {32'b0, step_x_reg};
            REG_STEP_Y:  prdata = {32'b0, step_y_reg};
            REG_ROT_T:   prdata = {4'b0, rot_t_reg};
            REG_ROT_S:   prdata = {4'b0, rot_s_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.mag     = mode_reg;
    assign cfg.accel_x = accel_x_reg;
    assign cfg.accel_y = accel_y_reg;
    assign cfg.step_x  = step_x_reg;
    assign cfg.step_y  = step_y_reg;
    assign cfg.rot_t   = rot_t_reg;
    assign cfg.rot_s   = rot_s_reg;

    ppb_front #(
        .CELLS_X (CELLS_X),
        .CELLS_Y (CELLS_Y)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_data   (q_in_data)
    );

    ppb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_pop   (q_pop),
        .out_data  (q_out_data)
    );

    ppb_back #(
        .CELLS_X (CELLS_X),
        .CELLS_Y (CELLS_Y)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_out_valid),
        .q_pop    (q_pop),
        .q_data   (q_out_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: design/ppb_checker.sv
module ppb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ppb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [ppb_pkg::APB_AW-1:0]    paddr,
    input logic [ppb_pkg::APB_DW-1:0]    pwdata,
    input logic [ppb_pkg::APB_DW-1:0]    prdata
);

    // A stalled result beat holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Reset leaves the block empty and ready for input.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not empty after reset");

    // A negative new position always lies off the grid.
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[31] || m_tdata[63]) |-> m_tuser[0])
        else $error("negative position without out-of-grid flag");

    // The mode register reads back what was written.
    a_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && paddr[5:3] == 3'd0
        |=> paddr[5:3] != 3'd0 || prdata[0] == $past(pwdata[0]))
        else $error("mode register readback mismatch");

endmodule

bind pic_particle_push_bilinear_top ppb_checker u_ppb_checker (.*);

// File: tb/push_checker.sv
module push_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ppb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ppb_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [0:0]                    m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppb_pkg::APB_AW-1:0]    paddr,
    input  logic [ppb_pkg::APB_DW-1:0]    pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending
);
    import ppb_pkg::*;

    localparam int NX = 64;
    localparam int NY = 64;

    typedef struct {
        logic [159:0] data;
        logic         off;
    } particle_out_t;

    logic               mag_q;
    longint             acc_sx, acc_sy, stp_sx, stp_sy;
    logic [59:0]        rot_t_q, rot_s_q;
    longint             grid_ax [(NX+1)*(NY+1)];
    longint             grid_ay [(NX+1)*(NY+1)];
    particle_out_t      push_results [$];

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Exact product, rounded half up at bit 16 (>>> floors).
    function automatic longint qprod(input longint a, input longint b);
        return (a * b + 64'sd32768) >>> 16;
    endfunction

    function automatic longint s20(input logic [19:0] v);
        return longint'(signed'(v));
    endfunction

    task automatic push_particle(input logic [223:0] d);
        longint px, py, vx, vy, vz, fx, fy, ix, iy, w1, w2, w3, w4, ax, ay;
        longint ux, uy, uz, rx, ry, rz, tx, ty, tz, sx, sy, sz, nx, ny;
        int n1, n2, n3, n4;
        particle_out_t r;
        px = d[99:78];
        py = d[121:100];
        vx = longint'(signed'(d[153:122]));
        vy = longint'(signed'(d[185:154]));
        vz = longint'(signed'(d[217:186]));
        ix = px >> 16; iy = py >> 16;
        fx = px & 16'hFFFF; fy = py & 16'hFFFF;
        // Past the last cell the gather pins to the edge nodes.
        if (ix >= NX) begin ix = NX - 1; fx = 65536; end
        if (iy >= NY) begin iy = NY - 1; fy = 65536; end
        w1 = ((65536 - fx) * (65536 - fy) + 32768) >>> 16;
        w2 = (fx * (65536 - fy) + 32768) >>> 16;
        w3 = ((65536 - fx) * fy + 32768) >>> 16;
        w4 = (fx * fy + 32768) >>> 16;
        n1 = int'(ix * (NY + 1) + iy);
        n2 = n1 + NY + 1;
        n3 = n1 + 1;
        n4 = n2 + 1;
        ax = clip32((grid_ax[n1]*w1 + grid_ax[n2]*w2 + grid_ax[n3]*w3
                     + grid_ax[n4]*w4 + 32768) >>> 16);
        ay = clip32((grid_ay[n1]*w1 + grid_ay[n2]*w2 + grid_ay[n3]*w3
                     + grid_ay[n4]*w4 + 32768) >>> 16);
        ux = clip32(vx + ax);
        uy = clip32(vy + ay);
        uz = vz;
        if (!mag_q) begin
            nx = clip32(px + ux);
            ny = clip32(py + uy);
        end else begin
            tx = s20(rot_t_q[19:0]); ty = s20(rot_t_q[39:20]); tz = s20(rot_t_q[59:40]);
            sx = s20(rot_s_q[19:0]); sy = s20(rot_s_q[39:20]); sz = s20(rot_s_q[59:40]);
            rx = clip32(ux + qprod(uy, tz) - qprod(uz, ty));
            ry = clip32(uy + qprod(uz, tx) - qprod(ux, tz));
            rz = clip32(uz + qprod(ux, ty) - qprod(uy, tx));
            ux = clip32(ux + qprod(ry, sz) - qprod(rz, sy));
            uy = clip32(uy + qprod(rz, sx) - qprod(rx, sz));
            uz = clip32(uz + qprod(rx, sy) - qprod(ry, sx));
            ux = clip32(ux + ax);
            uy = clip32(uy + ay);
            nx = clip32(px + qprod(stp_sx, ux));
            ny = clip32(py + qprod(stp_sy, uy));
        end
        r.data = {uz[31:0], uy[31:0], ux[31:0], ny[31:0], nx[31:0]};
        r.off  = (nx < 0 || ny < 0 || nx >= NX * 65536 || ny >= NY * 65536);
        push_results.push_back(r);
    endtask

    always @(posedge aclk) begin
        int k;
        particle_out_t e;
        if (!aresetn) begin
            mag_q   <= 1'b0;
            acc_sx  = 65536; acc_sy = 65536;
            stp_sx  = 65536; stp_sy = 65536;
            rot_t_q <= '0;
            rot_s_q <= '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[5:3]))
                    REG_MODE:    mag_q <= pwdata[0];
                    REG_ACCEL_X: acc_sx = longint'(signed'(pwdata[31:0]));
                    REG_ACCEL_Y: acc_sy = longint'(signed'(pwdata[31:0]));
                    REG_STEP_X:  stp_sx = longint'(signed'(pwdata[31:0]));
                    REG_STEP_Y:  stp_sy = longint'(signed'(pwdata[31:0]));
                    REG_ROT_T:   rot_t_q <= pwdata[59:0];
                    REG_ROT_S:   rot_s_q <= pwdata[59:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0]) begin
                    push_particle(s_tdata);
                end else if (s_tdata[6:0] <= NX && s_tdata[13:7] <= NY) begin
                    k = s_tdata[6:0] * (NY + 1) + s_tdata[13:7];
                    grid_ax[k] = clip32(qprod(longint'(signed'(s_tdata[45:14])), acc_sx));
                    grid_ay[k] = clip32(qprod(longint'(signed'(s_tdata[77:46])), acc_sy));
                end
            end
            if (m_tvalid && m_tready) begin
                if (push_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h/%b", $time, m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    e = push_results.pop_front();
                    for (int f = 0; f < 5; f++) begin
                        if (m_tdata[f*32 +: 32] !== e.data[f*32 +: 32]) begin
                            $display("%0t: field %0d expected %h actual %h", $time, f,
                                     e.data[f*32 +: 32], m_tdata[f*32 +: 32]);
                            fail_count++;
                        end
                    end
                    if (m_tuser[0] !== e.off) begin
                        $display("%0t: out_of_grid expected %b actual %b", $time, e.off,
                                 m_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
        pending = push_results.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
    end
endmodule

// File: tb/tb_top.sv
module tb_top;
    import ppb_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    int                   fail_count, pending;
    bit                   loaded [65][65];

    always #5 aclk = ~aclk;

    pic_particle_push_bilinear_top uut (.*);
    push_checker chk (.*);

    // Receiver stalls follow their own slowly changing duty cycle.
    always @(posedge aclk) begin
        int duty;
        if ($urandom_range(0, 199) == 0) duty = $urandom_range(0, 3);
        case (duty)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic reg_write(input reg_idx_t idx, input logic [63:0] v);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= APB_AW'(idx) << 3; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_beat(input logic is_push, input logic [223:0] d);
        s_tvalid <= 1'b1; s_tuser <= is_push; s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic load_node(input int i, input int j, input logic [31:0] ex,
                             input logic [31:0] ey);
        if (i <= 64 && j <= 64) loaded[i][j] = 1'b1;
        send_beat(1'b0, {146'd0, ey, ex, 7'(j), 7'(i)});
    endtask

    task automatic push_part(input logic [21:0] px, input logic [21:0] py,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz);
        send_beat(1'b1, {6'd0, vz, vy, vx, py, px, 78'd0});
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // Most positions fall in the cells whose corner nodes were loaded first.
    function automatic logic [21:0] rnd_pos(input bit wide);
        int cells [6];
        cells = '{0, 1, 31, 32, 62, 63};
        if (wide && $urandom_range(0, 7) == 0) return 22'($urandom);
        return {6'(cells[$urandom_range(0, 5)]), 16'($urandom)};
    endfunction

    // Positions whose four corner nodes are all loaded are the only legal ones.
    function automatic bit gather_ok(input logic [21:0] px, input logic [21:0] py);
        int ix, iy;
        ix = px >> 16; iy = py >> 16;
        if (ix > 63) ix = 63;
        if (iy > 63) iy = 63;
        return loaded[ix][iy] && loaded[ix+1][iy] && loaded[ix][iy+1] && loaded[ix+1][iy+1];
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        logic [21:0] px, py;
        int cidx [9];
        cidx = '{0, 1, 2, 31, 32, 33, 62, 63, 64};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load the nodes around a few cells at both edges and in the middle.
        for (int a = 0; a < 9; a++)
            for (int b = 0; b < 9; b++)
                load_node(cidx[a], cidx[b], rnd_val(), rnd_val());
        // Directed: ignored loads, field extremes, grid edges, clamp past last cell.
        load_node(65, 3, 32'h12345678, 32'h1);
        load_node(127, 127, 32'hffffffff, 32'h0);
        load_node(0, 0, 32'h7fffffff, 32'h80000000);
        load_node(64, 64, 32'h80000000, 32'h7fffffff);
        push_part(22'd0, 22'd0, 32'h7fffffff, 32'h80000000, 32'h0);
        push_part(22'h3fffff, 22'h3fffff, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        push_part(22'h3fffff, 22'd0, 32'h0, 32'h0, 32'h7fffffff);
        push_part(22'h3fffff, 22'h000001, 32'hffffffff, 32'h1, 32'h80000000);
        push_part(22'h20_8000, 22'h1f_8000, 32'h10000, 32'hffff0000, 32'h1234);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            reg_write(REG_MODE, 64'(phase % 2));
            reg_write(REG_ACCEL_X, (phase == 2) ? 64'h7fffffff : (phase == 3) ?
                      64'h80000000 : 64'($urandom_range(0, 131072)));
            reg_write(REG_ACCEL_Y, (phase == 2) ? 64'h80000000 : 64'($urandom));
            reg_write(REG_STEP_X, (phase == 3) ? 64'h7fffffff : 64'($urandom));
            reg_write(REG_STEP_Y, (phase == 5) ? 64'h80000000 :
                      64'($urandom_range(0, 65536)));
            reg_write(REG_ROT_T, (phase == 3) ? 64'h0fffffffffffffff :
                      (phase == 5) ? 64'h0800008000080000 : {$urandom, $urandom});
            reg_write(REG_ROT_S, (phase == 3) ? 64'h0800008000080000 : {$urandom, $urandom});
            @(posedge aclk);
            for (int n = 0; n < 85; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    load_node($urandom_range(0, 70), $urandom_range(0, 70),
                              rnd_val(), rnd_val());
                end else begin
                    do begin
                        px = rnd_pos(1); py = rnd_pos(1);
                    end while (!gather_ok(px, py));
                    push_part(px, py, rnd_val(), rnd_val(), rnd_val());
                end
                if (n == 40) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (pending != 0) @(posedge aclk);
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS pic_particle_push_bilinear_top");
        end else begin
            $display("FAIL pic_particle_push_bilinear_top");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL pic_particle_push_bilinear_top");
        $finish;
    end
endmodule

// File: filelist.f
design/ppb_pkg.sv
design/ppb_front.sv
design/ppb_queue.sv
design/ppb_back.sv
design/pic_particle_push_bilinear_top.sv
design/ppb_checker.sv
tb/push_checker.sv
tb/tb_top.sv
